// File: src/bcpm_pkg.sv
package bcpm_pkg;

    localparam int SAMPLE_BITS   = 12;
    localparam int MAX_DEGREE    = 2;
    localparam int MAX_PAIRS_DEF = 4096;

    localparam int DEV_W  = SAMPLE_BITS + 1;
    localparam int FAC_W  = 2 * SAMPLE_BITS;
    localparam int PROD_W = 2 * FAC_W;
    localparam int ACC_W  = 61;
    localparam int OUT_W  = 57;
    localparam int COV_W  = 58;
    localparam int TOT_W  = OUT_W + 2;
    localparam int DIVD_W = OUT_W + 16;
    localparam int DIVS_W = TOT_W;
    localparam int AF_W   = 16;
    localparam int AF_FRAC = 14;
    localparam int DEG_W  = 2;
    localparam int LO_W   = 29;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [ACC_W-1:0] ACC_MAX = '1;
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_DEG  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_DEG  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POP_EN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ADJ_FACTOR = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_NORM_EN    = 3'd6;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] thresh_x;
        logic signed [SAMPLE_BITS-1:0] thresh_y;
        logic [DEG_W-1:0]              lower_degree;
        logic [DEG_W-1:0]              upper_degree;
        logic                          pop_en;
        logic [AF_W-1:0]               adjust_factor;
        logic                          norm_en;
    } t_cfg;

    typedef struct packed {
        logic       acc_en;
        logic       div_start;
        logic       div_norm;
        logic       mean_wb;
        logic       norm_wb;
        logic       adj_lo;
        logic       adj_hi;
        logic       cov_en;
        logic       zero_m;
        logic       load_out;
        logic [1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic pipe_empty;
        logic div_done;
        logic div_busy;
        logic adj_on;
        logic norm_on;
        logic total_zero;
        logic out_free;
    } t_stat;

    function automatic logic [DEG_W-1:0] clamp_deg(input logic [DEG_W-1:0] deg);
        return (deg > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : deg;
    endfunction

    // d is the deviation toward the side; strict picks > over >= for the indicator
    function automatic logic [FAC_W-1:0] side_factor(input logic signed [DEV_W-1:0] d,
                                                     input logic [DEG_W-1:0] deg,
                                                     input logic strict);
        logic [SAMPLE_BITS-1:0] mag;
        logic [FAC_W-1:0]       r;
        mag = d[SAMPLE_BITS-1:0];
        if (deg == '0) begin
            r = (strict ? (d > 0) : (d >= 0)) ? FAC_W'(1) : '0;
        end else if (d <= 0) begin
            r = '0;
        end else if (deg == DEG_W'(1)) begin
            r = FAC_W'(mag);
        end else begin
            r = FAC_W'(mag) * FAC_W'(mag);
        end
        return r;
    endfunction

endpackage

// File: src/bivariate_copartial_moment_set_core.sv
// Co-partial moment engine for paired signed samples. Pairs stream in at one per cycle
// while the core accumulates and feed four saturating 61-bit sums (co-lower, co-upper,
// discordant-lower, discordant-upper); the pair marked last closes the data set. Closing
// divides the four sums into means, applies the population factor when it applies, forms
// the covariance, and normalises the four means with normalising on; the shared restoring
// divider retires one quotient bit per cycle over 73 bits. No pair is taken while a set
// closes; the previous result may still wait in the output register meanwhile.
// Configuration writes are taken every cycle outside reset and belong between data sets.
module bivariate_copartial_moment_set_core #(
    parameter int MAX_PAIRS = bcpm_pkg::MAX_PAIRS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic signed [bcpm_pkg::SAMPLE_BITS-1:0] i_sample_x,
    input  logic signed [bcpm_pkg::SAMPLE_BITS-1:0] i_sample_y,
    input  logic                                    i_last_sample,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic [bcpm_pkg::OUT_W-1:0]              o_co_lower_moment,
    output logic [bcpm_pkg::OUT_W-1:0]              o_co_upper_moment,
    output logic [bcpm_pkg::OUT_W-1:0]              o_disc_lower_moment,
    output logic [bcpm_pkg::OUT_W-1:0]              o_disc_upper_moment,
    output logic signed [bcpm_pkg::COV_W-1:0]       o_covariance,
    output logic                                    o_saturated,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [bcpm_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [bcpm_pkg::CFG_DAT_W-1:0]          i_cfg_data
);
    bcpm_pkg::t_cfg  r_cfg;
    bcpm_pkg::t_cmd  w_cmd;
    bcpm_pkg::t_stat w_stat;
    logic            w_fire;

    assign o_cfg_ready = i_rst_n;
    assign o_ready     = w_cmd.acc_en && i_rst_n;
    assign w_fire      = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thresh_x      <= '0;
            r_cfg.thresh_y      <= '0;
            r_cfg.lower_degree  <= bcpm_pkg::DEG_W'(1);
            r_cfg.upper_degree  <= bcpm_pkg::DEG_W'(1);
            r_cfg.pop_en        <= 1'b0;
            r_cfg.adjust_factor <= bcpm_pkg::AF_W'(16384);
            r_cfg.norm_en       <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bcpm_pkg::CFG_THRESH_X:
                    r_cfg.thresh_x <= i_cfg_data[bcpm_pkg::SAMPLE_BITS-1:0];
                bcpm_pkg::CFG_THRESH_Y:
                    r_cfg.thresh_y <= i_cfg_data[bcpm_pkg::SAMPLE_BITS-1:0];
                bcpm_pkg::CFG_LOWER_DEG:
                    r_cfg.lower_degree <= i_cfg_data[bcpm_pkg::DEG_W-1:0];
                bcpm_pkg::CFG_UPPER_DEG:
                    r_cfg.upper_degree <= i_cfg_data[bcpm_pkg::DEG_W-1:0];
                bcpm_pkg::CFG_POP_EN:     r_cfg.pop_en <= i_cfg_data[0];
                bcpm_pkg::CFG_ADJ_FACTOR:
                    r_cfg.adjust_factor <= i_cfg_data[bcpm_pkg::AF_W-1:0];
                bcpm_pkg::CFG_NORM_EN:    r_cfg.norm_en <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    bcpm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_last  (i_last_sample),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    bcpm_dp #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (r_cfg),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat),
        .i_fire              (w_fire),
        .i_sample_x          (i_sample_x),
        .i_sample_y          (i_sample_y),
        .i_ready             (i_ready),
        .o_valid             (o_valid),
        .o_co_lower_moment   (o_co_lower_moment),
        .o_co_upper_moment   (o_co_upper_moment),
        .o_disc_lower_moment (o_disc_lower_moment),
        .o_disc_upper_moment (o_disc_upper_moment),
        .o_covariance        (o_covariance),
        .o_saturated         (o_saturated)
    );

    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_last_sample) |=> !o_ready)
        else $error("input still taken after a last item");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |-> !w_stat.div_busy)
        else $error("divider started while busy");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> w_stat.out_free)
        else $error("result loaded over a waiting item");

    a_pipe_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |-> w_stat.pipe_empty)
        else $error("division began before accumulation drained");
endmodule

// File: src/bcpm_div.sv
module bcpm_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [bcpm_pkg::DIVD_W-1:0]    i_dividend,
    input  logic [bcpm_pkg::DIVS_W-1:0]    i_divisor,
    output logic                           o_busy,
    output logic                           o_done,
    output logic [bcpm_pkg::DIVD_W-1:0]    o_quotient
);
    localparam int STEP_W = $clog2(bcpm_pkg::DIVD_W);

    logic                          r_busy, r_done;
    logic [STEP_W-1:0]             r_cnt;
    logic [bcpm_pkg::DIVD_W-1:0]   r_quo;
    logic [bcpm_pkg::DIVS_W-1:0]   r_rem, r_den;
    logic [bcpm_pkg::DIVS_W:0]     w_trial;
    logic                          w_ge;

    assign w_trial = {r_rem, r_quo[bcpm_pkg::DIVD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(bcpm_pkg::DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle, restoring
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[bcpm_pkg::DIVD_W-2:0], w_ge};
            r_rem <= w_ge ? bcpm_pkg::DIVS_W'(w_trial - {1'b0, r_den})
                          : bcpm_pkg::DIVS_W'(w_trial);
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

// File: src/bcpm_dp.sv
module bcpm_dp #(
    parameter int MAX_PAIRS = bcpm_pkg::MAX_PAIRS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  bcpm_pkg::t_cfg                         i_cfg,
    input  bcpm_pkg::t_cmd                         i_cmd,
    output bcpm_pkg::t_stat                        o_stat,
    input  logic                                   i_fire,
    input  logic signed [bcpm_pkg::SAMPLE_BITS-1:0] i_sample_x,
    input  logic signed [bcpm_pkg::SAMPLE_BITS-1:0] i_sample_y,
    input  logic                                   i_ready,
    output logic                                   o_valid,
    output logic [bcpm_pkg::OUT_W-1:0]             o_co_lower_moment,
    output logic [bcpm_pkg::OUT_W-1:0]             o_co_upper_moment,
    output logic [bcpm_pkg::OUT_W-1:0]             o_disc_lower_moment,
    output logic [bcpm_pkg::OUT_W-1:0]             o_disc_upper_moment,
    output logic signed [bcpm_pkg::COV_W-1:0]      o_covariance,
    output logic                                   o_saturated
);
    localparam int CNT_W  = $clog2(MAX_PAIRS + 1);
    localparam int ACC_W  = bcpm_pkg::ACC_W;
    localparam int OUT_W  = bcpm_pkg::OUT_W;
    localparam int FAC_W  = bcpm_pkg::FAC_W;
    localparam int DEV_W  = bcpm_pkg::DEV_W;
    localparam int DIVD_W = bcpm_pkg::DIVD_W;
    localparam int DIVS_W = bcpm_pkg::DIVS_W;
    localparam int TOT_W  = bcpm_pkg::TOT_W;
    localparam int AF_W   = bcpm_pkg::AF_W;
    localparam int LO_W   = bcpm_pkg::LO_W;
    localparam int PP_W   = LO_W + AF_W;
    localparam int HI_W   = OUT_W - LO_W;
    localparam int FULL_W = OUT_W + AF_W;
    localparam int V_W    = FULL_W - bcpm_pkg::AF_FRAC;

    logic [bcpm_pkg::DEG_W-1:0] w_dl, w_du;
    logic signed [DEV_W-1:0]    w_dxl, w_dyl, w_dxu, w_dyu;

    logic                r_s1_vld;
    logic [FAC_W-1:0]    r_lx, r_ly, r_ux, r_uy;
    logic [ACC_W-1:0]    r_sum [4];
    logic [CNT_W-1:0]    r_count;
    logic                r_ovf, r_rsat;
    logic [OUT_W-1:0]    r_m [4];
    logic [PP_W-1:0]     r_pp;
    logic [bcpm_pkg::COV_W-1:0] r_cov;
    logic [TOT_W-1:0]    r_total;

    logic                r_o_vld, r_o_sat;
    logic [OUT_W-1:0]    r_o_m [4];
    logic [bcpm_pkg::COV_W-1:0] r_o_cov;

    logic [bcpm_pkg::PROD_W-1:0] w_prod [4];
    logic [ACC_W:0]      w_add [4];
    logic                w_full;

    logic [DIVD_W-1:0]   w_dividend;
    logic [DIVS_W-1:0]   w_divisor;
    logic                w_div_busy, w_div_done;
    logic [DIVD_W-1:0]   w_quo;

    logic [HI_W+AF_W-1:0] w_hi;
    logic [FULL_W-1:0]   w_full_prod;
    logic [V_W-1:0]      w_adj;
    logic signed [OUT_W+2:0] w_cov;
    logic [TOT_W-1:0]    w_total;

    assign w_dl  = bcpm_pkg::clamp_deg(i_cfg.lower_degree);
    assign w_du  = bcpm_pkg::clamp_deg(i_cfg.upper_degree);
    assign w_dxl = DEV_W'(i_cfg.thresh_x) - DEV_W'(i_sample_x);
    assign w_dyl = DEV_W'(i_cfg.thresh_y) - DEV_W'(i_sample_y);
    assign w_dxu = DEV_W'(i_sample_x) - DEV_W'(i_cfg.thresh_x);
    assign w_dyu = DEV_W'(i_sample_y) - DEV_W'(i_cfg.thresh_y);
    assign w_full = (r_count == CNT_W'(MAX_PAIRS));

    assign w_prod[0] = r_lx * r_ly;
    assign w_prod[1] = r_ux * r_uy;
    assign w_prod[2] = r_ux * r_ly;
    assign w_prod[3] = r_lx * r_uy;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_add[k] = {1'b0, r_sum[k]} + (ACC_W + 1)'(w_prod[k]);
        end
    end

    // factor stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_fire && !w_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_lx <= bcpm_pkg::side_factor(w_dxl, w_dl, 1'b0);
            r_ly <= bcpm_pkg::side_factor(w_dyl, w_dl, 1'b0);
            r_ux <= bcpm_pkg::side_factor(w_dxu, w_du, 1'b1);
            r_uy <= bcpm_pkg::side_factor(w_dyu, w_du, 1'b1);
        end
    end

    assign w_dividend = i_cmd.div_norm ? {r_m[i_cmd.idx], 16'b0}
                                       : DIVD_W'({r_sum[i_cmd.idx], 8'b0});
    assign w_divisor  = i_cmd.div_norm ? DIVS_W'(r_total) : DIVS_W'(r_count);

    bcpm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_hi        = r_m[i_cmd.idx][OUT_W-1:LO_W] * i_cfg.adjust_factor;
    assign w_full_prod = {w_hi, {LO_W{1'b0}}} + FULL_W'(r_pp);
    assign w_adj       = w_full_prod[FULL_W-1:bcpm_pkg::AF_FRAC];

    assign w_cov = (OUT_W+3)'(r_m[1]) + (OUT_W+3)'(r_m[0])
                 - (OUT_W+3)'(r_m[3]) - (OUT_W+3)'(r_m[2]);
    assign w_total = TOT_W'(r_m[0]) + TOT_W'(r_m[1]) + TOT_W'(r_m[2]) + TOT_W'(r_m[3]);

    // accumulators, count and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_out) begin
            for (int k = 0; k < 4; k++) begin
                r_sum[k] <= '0;
            end
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_rsat  <= 1'b0;
        end else begin
            if (i_fire) begin
                if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (r_s1_vld) begin
                for (int k = 0; k < 4; k++) begin
                    if (w_add[k] > (ACC_W + 1)'(bcpm_pkg::ACC_MAX)) begin
                        r_sum[k] <= bcpm_pkg::ACC_MAX;
                        r_ovf    <= 1'b1;
                    end else begin
                        r_sum[k] <= w_add[k][ACC_W-1:0];
                    end
                end
            end
            if (w_div_done && i_cmd.mean_wb && (w_quo[DIVD_W-1:OUT_W] != '0)) begin
                r_rsat <= 1'b1;
            end
            if (i_cmd.adj_hi && (w_adj[V_W-1:OUT_W] != '0)) begin
                r_rsat <= 1'b1;
            end
            if (i_cmd.cov_en && (w_cov[OUT_W+2:OUT_W] != {3{w_cov[OUT_W]}})) begin
                r_rsat <= 1'b1;
            end
        end
    end

    // finishing arithmetic on the moments
    always_ff @(posedge i_clk) begin
        if (w_div_done && i_cmd.mean_wb) begin
            r_m[i_cmd.idx] <= (w_quo[DIVD_W-1:OUT_W] != '0) ? bcpm_pkg::OUT_MAX
                                                           : w_quo[OUT_W-1:0];
        end
        if (w_div_done && i_cmd.norm_wb) begin
            r_m[i_cmd.idx] <= w_quo[OUT_W-1:0];
        end
        if (i_cmd.adj_lo) begin
            r_pp <= r_m[i_cmd.idx][LO_W-1:0] * i_cfg.adjust_factor;
        end
        if (i_cmd.adj_hi) begin
            r_m[i_cmd.idx] <= (w_adj[V_W-1:OUT_W] != '0) ? bcpm_pkg::OUT_MAX
                                                        : w_adj[OUT_W-1:0];
        end
        if (i_cmd.cov_en) begin
            r_total <= w_total;
            if (w_cov[OUT_W+2:OUT_W] == {3{w_cov[OUT_W]}}) begin
                r_cov <= w_cov[bcpm_pkg::COV_W-1:0];
            end else if (w_cov[OUT_W+2]) begin
                r_cov <= {1'b1, {(bcpm_pkg::COV_W-1){1'b0}}};
            end else begin
                r_cov <= {1'b0, {(bcpm_pkg::COV_W-1){1'b1}}};
            end
        end
        if (i_cmd.zero_m) begin
            for (int k = 0; k < 4; k++) begin
                r_m[k] <= '0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_o_vld <= 1'b1;
        end else if (i_ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            for (int k = 0; k < 4; k++) begin
                r_o_m[k] <= r_m[k];
            end
            r_o_cov <= r_cov;
            r_o_sat <= r_ovf || r_rsat;
        end
    end

    assign o_stat.pipe_empty = !r_s1_vld;
    assign o_stat.div_done   = w_div_done;
    assign o_stat.div_busy   = w_div_busy;
    assign o_stat.adj_on     = i_cfg.pop_en && (r_count > CNT_W'(1))
                             && (w_dl != '0) && (w_du != '0);
    assign o_stat.norm_on    = i_cfg.norm_en;
    assign o_stat.total_zero = (r_total == '0);
    assign o_stat.out_free   = !r_o_vld || i_ready;

    assign o_valid             = r_o_vld;
    assign o_co_lower_moment   = r_o_m[0];
    assign o_co_upper_moment   = r_o_m[1];
    assign o_disc_lower_moment = r_o_m[2];
    assign o_disc_upper_moment = r_o_m[3];
    assign o_covariance        = r_o_cov;
    assign o_saturated         = r_o_sat;
endmodule

// File: src/bcpm_ctrl.sv
module bcpm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  logic            i_last,
    input  bcpm_pkg::t_stat i_stat,
    output bcpm_pkg::t_cmd  o_cmd
);
    typedef enum logic [9:0] {
        S_ACCUM     = 10'b0000000001,
        S_DRAIN     = 10'b0000000010,
        S_MEAN_GO   = 10'b0000000100,
        S_MEAN_WAIT = 10'b0000001000,
        S_ADJ_LO    = 10'b0000010000,
        S_ADJ_HI    = 10'b0000100000,
        S_COV       = 10'b0001000000,
        S_NORM_GO   = 10'b0010000000,
        S_NORM_WAIT = 10'b0100000000,
        S_DONE      = 10'b1000000000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACCUM;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        o_cmd.idx = r_idx;
        unique case (r_state)
            S_ACCUM: begin
                o_cmd.acc_en = 1'b1;
                if (i_fire && i_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_stat.pipe_empty) begin
                    n_state = S_MEAN_GO;
                    n_idx   = '0;
                end
            end
            S_MEAN_GO: begin
                o_cmd.div_start = 1'b1;
                n_state = S_MEAN_WAIT;
            end
            S_MEAN_WAIT: begin
                o_cmd.mean_wb = 1'b1;
                if (i_stat.div_done) begin
                    n_idx = r_idx + 1'b1;
                    if (r_idx != 2'd3) begin
                        n_state = S_MEAN_GO;
                    end else if (i_stat.adj_on) begin
                        n_state = S_ADJ_LO;
                    end else begin
                        n_state = S_COV;
                    end
                end
            end
            S_ADJ_LO: begin
                o_cmd.adj_lo = 1'b1;
                n_state = S_ADJ_HI;
            end
            S_ADJ_HI: begin
                o_cmd.adj_hi = 1'b1;
                n_idx   = r_idx + 1'b1;
                n_state = (r_idx == 2'd3) ? S_COV : S_ADJ_LO;
            end
            S_COV: begin
                o_cmd.cov_en = 1'b1;
                n_idx   = '0;
                n_state = i_stat.norm_on ? S_NORM_GO : S_DONE;
            end
            S_NORM_GO: begin
                o_cmd.div_norm = 1'b1;
                if (i_stat.total_zero) begin
                    o_cmd.zero_m = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_NORM_WAIT;
                end
            end
            S_NORM_WAIT: begin
                o_cmd.norm_wb = 1'b1;
                if (i_stat.div_done) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = (r_idx == 2'd3) ? S_DONE : S_NORM_GO;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_idx   = '0;
                    n_state = S_ACCUM;
                end
            end
            default: begin
                n_state = S_ACCUM;
            end
        endcase
    end
endmodule

// File: test/tb_bivariate_copartial_moment_set_core.sv
`timescale 1ns / 1ps

module tb_bivariate_copartial_moment_set_core;
    localparam int OUT_W         = bcpm_pkg::OUT_W;
    localparam int COV_W         = bcpm_pkg::COV_W;
    localparam int CFG_IDX_W     = bcpm_pkg::CFG_IDX_W;
    localparam int CFG_DAT_W     = bcpm_pkg::CFG_DAT_W;
    localparam int SAMPLE_BITS   = bcpm_pkg::SAMPLE_BITS;
    localparam int MAX_DEGREE    = bcpm_pkg::MAX_DEGREE;
    localparam int MAX_PAIRS_DEF = bcpm_pkg::MAX_PAIRS_DEF;

    typedef struct {
        logic [OUT_W-1:0]        co_lower;
        logic [OUT_W-1:0]        co_upper;
        logic [OUT_W-1:0]        disc_lower;
        logic [OUT_W-1:0]        disc_upper;
        logic signed [COV_W-1:0] cov;
        logic                    sat;
    } t_moment_set;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DAT_W-1:0] data;
        int                   x;
        int                   y;
        bit                   last;
        bit                   has_exp;
        t_moment_set          exp_set;
    } t_dir_row;

    localparam longint unsigned SUM_CAP = (64'd1 << 61) - 1;
    localparam longint unsigned MEAN_CAP = (64'd1 << 57) - 1;
    localparam longint COV_HI = (64'sd1 <<< 57) - 1;
    localparam longint COV_LO = -(64'sd1 <<< 57);

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_ready;
    logic signed [SAMPLE_BITS-1:0] i_sample_x = '0;
    logic signed [SAMPLE_BITS-1:0] i_sample_y = '0;
    logic                    i_last_sample = 1'b0;
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    logic [OUT_W-1:0]        o_co_lower_moment;
    logic [OUT_W-1:0]        o_co_upper_moment;
    logic [OUT_W-1:0]        o_disc_lower_moment;
    logic [OUT_W-1:0]        o_disc_upper_moment;
    logic signed [COV_W-1:0] o_covariance;
    logic                    o_saturated;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]    i_cfg_data = '0;

    bivariate_copartial_moment_set_core dut (.*);

    always #10 i_clk = ~i_clk;

    // predictor configuration and running sums
    longint          tgt_x, tgt_y;
    int unsigned     deg_lo, deg_hi;
    bit              pop_on, norm_on;
    longint unsigned adj_q14;
    longint unsigned sum_cl, sum_cu, sum_dl, sum_du;
    int unsigned     pairs_seen;
    bit              sum_ovf;

    t_moment_set expected_moments[$];
    int  errors = 0;
    int  results_seen = 0;
    int  items_sent = 0;
    int  sets_sent = 0;
    bit  hold_req = 1'b0;
    bit  no_gaps = 1'b0;

    function automatic longint unsigned sat_mul(longint unsigned a, longint unsigned b,
                                                longint unsigned cap, inout bit flag);
        if (a != 0 && b > cap / a) begin
            flag = 1'b1;
            return cap;
        end
        if (a * b > cap) begin
            flag = 1'b1;
            return cap;
        end
        return a * b;
    endfunction

    function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b,
                                                longint unsigned cap, inout bit flag);
        if (a > cap || b > cap - a) begin
            flag = 1'b1;
            return cap;
        end
        return a + b;
    endfunction

    function automatic longint unsigned dev_factor(longint d, int unsigned deg, bit strict);
        longint unsigned r;
        bit f;
        r = 1;
        f = sum_ovf;
        if (deg == 0) return strict ? (d > 0) : (d >= 0);
        if (d <= 0) return 0;
        for (int i = 0; i < deg; i++) r = sat_mul(r, longint'(d), SUM_CAP, f);
        sum_ovf = f;
        return r;
    endfunction

    function automatic longint unsigned mean_q8(longint unsigned s, longint unsigned n,
                                                inout bit flag);
        longint unsigned q, r;
        q = s / n;
        r = s % n;
        if (q > (MEAN_CAP >> 8)) begin
            flag = 1'b1;
            return MEAN_CAP;
        end
        q = (q << 8) + ((r << 8) / n);
        if (q > MEAN_CAP) begin
            flag = 1'b1;
            return MEAN_CAP;
        end
        return q;
    endfunction

    function automatic longint unsigned scale_pop(longint unsigned m, inout bit flag);
        longint unsigned v;
        v = (m >> 14) * adj_q14 + (((m & 64'h3FFF) * adj_q14) >> 14);
        if (v > MEAN_CAP) begin
            flag = 1'b1;
            return MEAN_CAP;
        end
        return v;
    endfunction

    function automatic longint unsigned share_q16(longint unsigned m, longint unsigned tot);
        longint unsigned ip, r, q;
        ip = m / tot;
        r = m % tot;
        q = 0;
        for (int i = 0; i < 16; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= tot) begin
                r = r - tot;
                q = q | 1;
            end
        end
        return ((ip << 16) | q) & MEAN_CAP;
    endfunction

    function automatic void clear_sums();
        sum_cl = 0; sum_cu = 0; sum_dl = 0; sum_du = 0;
        pairs_seen = 0;
        sum_ovf = 1'b0;
    endfunction

    function automatic void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
        case (idx)
            bcpm_pkg::CFG_THRESH_X:   tgt_x = longint'($signed(d[SAMPLE_BITS-1:0]));
            bcpm_pkg::CFG_THRESH_Y:   tgt_y = longint'($signed(d[SAMPLE_BITS-1:0]));
            bcpm_pkg::CFG_LOWER_DEG:  deg_lo = d[1:0];
            bcpm_pkg::CFG_UPPER_DEG:  deg_hi = d[1:0];
            bcpm_pkg::CFG_POP_EN:     pop_on = d[0];
            bcpm_pkg::CFG_ADJ_FACTOR: adj_q14 = d;
            bcpm_pkg::CFG_NORM_EN:    norm_on = d[0];
            default: ;
        endcase
    endfunction

    // accumulate one pair; on the last pair return the expected moment set
    function automatic bit step_moments(int x, int y, bit last, output t_moment_set res);
        int unsigned dl, du;
        longint unsigned lx, ly, ux, uy, n, tot;
        longint unsigned m[4];
        longint cov;
        bit f, sat;
        dl = (deg_lo > MAX_DEGREE) ? MAX_DEGREE : deg_lo;
        du = (deg_hi > MAX_DEGREE) ? MAX_DEGREE : deg_hi;
        if (pairs_seen >= MAX_PAIRS_DEF) begin
            sum_ovf = 1'b1;
        end else begin
            lx = dev_factor(tgt_x - x, dl, 1'b0);
            ly = dev_factor(tgt_y - y, dl, 1'b0);
            ux = dev_factor(x - tgt_x, du, 1'b1);
            uy = dev_factor(y - tgt_y, du, 1'b1);
            f = sum_ovf;
            sum_cl = sat_add(sum_cl, sat_mul(lx, ly, SUM_CAP, f), SUM_CAP, f);
            sum_cu = sat_add(sum_cu, sat_mul(ux, uy, SUM_CAP, f), SUM_CAP, f);
            sum_dl = sat_add(sum_dl, sat_mul(ux, ly, SUM_CAP, f), SUM_CAP, f);
            sum_du = sat_add(sum_du, sat_mul(lx, uy, SUM_CAP, f), SUM_CAP, f);
            sum_ovf = f;
            pairs_seen++;
        end
        if (!last) return 1'b0;
        sat = sum_ovf;
        n = pairs_seen;
        m[0] = mean_q8(sum_cl, n, sat);
        m[1] = mean_q8(sum_cu, n, sat);
        m[2] = mean_q8(sum_dl, n, sat);
        m[3] = mean_q8(sum_du, n, sat);
        if (pop_on && n > 1 && dl > 0 && du > 0)
            for (int k = 0; k < 4; k++) m[k] = scale_pop(m[k], sat);
        cov = longint'(m[1]) + longint'(m[0]) - longint'(m[3]) - longint'(m[2]);
        if (cov > COV_HI) begin
            cov = COV_HI;
            sat = 1'b1;
        end else if (cov < COV_LO) begin
            cov = COV_LO;
            sat = 1'b1;
        end
        if (norm_on) begin
            tot = m[0] + m[1] + m[2] + m[3];
            for (int k = 0; k < 4; k++) m[k] = (tot == 0) ? 0 : share_q16(m[k], tot);
        end
        res.co_lower   = m[0][OUT_W-1:0];
        res.co_upper   = m[1][OUT_W-1:0];
        res.disc_lower = m[2][OUT_W-1:0];
        res.disc_upper = m[3][OUT_W-1:0];
        res.cov        = cov[COV_W-1:0];
        res.sat        = sat;
        clear_sums();
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        set_reg(idx, d);
        @(posedge i_clk);
    endtask

    // drop the input and hold until every expected set has come and the core has drained
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_moments.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic send_pair(int x, int y, bit last, bit has_exp, t_moment_set typed);
        int g;
        t_moment_set res;
        g = pick_gap();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_sample_x    <= x[SAMPLE_BITS-1:0];
        i_sample_y    <= y[SAMPLE_BITS-1:0];
        i_last_sample <= last;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        if (step_moments(x, y, last, res)) begin
            sets_sent++;
            expected_moments.push_back(has_exp ? typed : res);
        end
    endtask

    task automatic send_set(int len, int spread);
        t_moment_set none;
        for (int i = 0; i < len; i++)
            send_pair($signed($urandom_range(0, 4095)) - 2048 >>> spread,
                      $signed($urandom_range(0, 4095)) - 2048 >>> spread,
                      i == len - 1, 1'b0, none);
    endtask

    // receiver: random backpressure, one long hold on request
    initial begin
        int hold_left;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_ready <= 1'b0;
                hold_left = 1500;
                while (hold_left > 0) begin
                    @(posedge i_clk);
                    hold_left--;
                end
                hold_req = 1'b0;
            end else if (!no_gaps && $urandom_range(0, 99) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(10, 60)) @(posedge i_clk);
            end else begin
                i_ready <= (no_gaps || $urandom_range(0, 3) != 0);
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_moment_set e;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (expected_moments.size() == 0) begin
                $error("unexpected result item");
                errors++;
            end else begin
                e = expected_moments.pop_front();
                if (o_co_lower_moment !== e.co_lower) begin
                    $error("co_lower_moment exp %0d got %0d", e.co_lower, o_co_lower_moment);
                    errors++;
                end
                if (o_co_upper_moment !== e.co_upper) begin
                    $error("co_upper_moment exp %0d got %0d", e.co_upper, o_co_upper_moment);
                    errors++;
                end
                if (o_disc_lower_moment !== e.disc_lower) begin
                    $error("disc_lower_moment exp %0d got %0d", e.disc_lower,
                           o_disc_lower_moment);
                    errors++;
                end
                if (o_disc_upper_moment !== e.disc_upper) begin
                    $error("disc_upper_moment exp %0d got %0d", e.disc_upper,
                           o_disc_upper_moment);
                    errors++;
                end
                if (o_covariance !== e.cov) begin
                    $error("covariance exp %0d got %0d", e.cov, o_covariance);
                    errors++;
                end
                if (o_saturated !== e.sat) begin
                    $error("saturated exp %0d got %0d", e.sat, o_saturated);
                    errors++;
                end
            end
        end
    end

    initial begin
        #40_000_000;
        $display("tb_bivariate_copartial_moment_set_core: FAIL");
        $finish;
    end

    initial begin
        t_dir_row    dir_rows[$];
        t_dir_row    row;
        t_moment_set zero_set;
        int          len;

        tgt_x = 0; tgt_y = 0; deg_lo = 1; deg_hi = 1;
        pop_on = 0; adj_q14 = 16384; norm_on = 0;
        clear_sums();
        zero_set = '{default: '0};

        // directed table: pair rows, with config rows between the data sets
        row = '{default: '0};
        row.last = 1; row.has_exp = 1; row.exp_set = zero_set;
        dir_rows.push_back(row);
        row.x = 2047; row.y = 2047;
        row.exp_set.co_upper = 1072693504; row.exp_set.cov = 1072693504;
        dir_rows.push_back(row);
        row = '{default: '0};
        row.x = -2048; row.y = -2048; row.last = 1; row.has_exp = 1;
        row.exp_set = zero_set;
        row.exp_set.co_lower = 1073741824; row.exp_set.cov = 1073741824;
        dir_rows.push_back(row);
        row = '{default: '0};
        row.x = -2048; row.y = 2047; dir_rows.push_back(row);
        row.x = 2047; row.y = -2048; row.last = 1; dir_rows.push_back(row);
        // indicator degrees; equal to target counts as lower only
        row = '{default: '0}; row.is_cfg = 1; row.idx = bcpm_pkg::CFG_LOWER_DEG;
        row.data = '0;
        dir_rows.push_back(row);
        row.idx = bcpm_pkg::CFG_UPPER_DEG; dir_rows.push_back(row);
        row = '{default: '0}; row.x = 0; row.y = 5; dir_rows.push_back(row);
        row.x = 3; row.y = -1; row.last = 1; dir_rows.push_back(row);
        // degree above max clamps, extreme targets, max adjust factor
        row = '{default: '0}; row.is_cfg = 1; row.idx = bcpm_pkg::CFG_LOWER_DEG;
        row.data = 16'd3;
        dir_rows.push_back(row);
        row.idx = bcpm_pkg::CFG_UPPER_DEG; row.data = 16'd3; dir_rows.push_back(row);
        row.idx = bcpm_pkg::CFG_THRESH_X; row.data = 16'hF800; dir_rows.push_back(row);
        row.idx = bcpm_pkg::CFG_THRESH_Y; row.data = 16'h0800; dir_rows.push_back(row);
        row.idx = bcpm_pkg::CFG_POP_EN; row.data = 16'd1; dir_rows.push_back(row);
        row.idx = bcpm_pkg::CFG_ADJ_FACTOR; row.data = 16'hFFFF; dir_rows.push_back(row);
        row = '{default: '0}; row.x = 2047; row.y = 2047; dir_rows.push_back(row);
        row.x = 2047; row.y = -2048; row.last = 1; dir_rows.push_back(row);
        // normalizing with a nonzero total, and with a zero total
        row = '{default: '0}; row.is_cfg = 1; row.idx = bcpm_pkg::CFG_NORM_EN;
        row.data = 16'd1;
        dir_rows.push_back(row);
        row.idx = bcpm_pkg::CFG_ADJ_FACTOR; row.data = '0; dir_rows.push_back(row);
        row = '{default: '0}; row.x = 100; row.y = 100; row.last = 1;
        dir_rows.push_back(row);
        row.x = -2048; row.y = 2047; row.last = 0; dir_rows.push_back(row);
        row.x = 2047; row.y = -2048; row.last = 1; dir_rows.push_back(row);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                wait_drained();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                send_pair(dir_rows[i].x, dir_rows[i].y, dir_rows[i].last,
                          dir_rows[i].has_exp, dir_rows[i].exp_set);
            end
        end

        // random phases, each with its own configuration
        for (int ph = 0; items_sent < 1750; ph++) begin
            wait_drained();
            write_reg(bcpm_pkg::CFG_THRESH_X, 16'($urandom));
            write_reg(bcpm_pkg::CFG_THRESH_Y, 16'($urandom));
            write_reg(bcpm_pkg::CFG_LOWER_DEG, 16'($urandom_range(0, 3)));
            write_reg(bcpm_pkg::CFG_UPPER_DEG, 16'($urandom_range(0, 3)));
            write_reg(bcpm_pkg::CFG_POP_EN, 16'($urandom_range(0, 1)));
            write_reg(bcpm_pkg::CFG_ADJ_FACTOR,
                      (ph % 4 == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535)));
            write_reg(bcpm_pkg::CFG_NORM_EN, 16'($urandom_range(0, 1)));
            no_gaps = (ph % 5 == 3);
            for (int s = 0; s < 25; s++) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 8);
                if (ph == 2 && s == 3) hold_req = 1'b1;
                send_set(len, (s % 6 == 5) ? 9 : 0);
            end
        end
        i_valid <= 1'b0;

        while (expected_moments.size() != 0) @(posedge i_clk);
        repeat (700) @(posedge i_clk);
        $display("covered %0d pairs in %0d data sets, %0d results checked, %0d errors",
                 items_sent, sets_sent, results_seen, errors);
        if (errors == 0) begin
            $display("tb_bivariate_copartial_moment_set_core: PASS");
        end else begin
            $display("tb_bivariate_copartial_moment_set_core: FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
src/bcpm_pkg.sv
src/bcpm_div.sv
src/bcpm_dp.sv
src/bcpm_ctrl.sv
src/bivariate_copartial_moment_set_core.sv
test/tb_bivariate_copartial_moment_set_core.sv
